// ===== rtl/assert_macros.svh =====
// Assertion macros used by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is high.
`define PTD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: property check failed");

// Condition that must never hold on a clock edge outside reset.
`define PTD_NEVER(label, clk, rst, expr) \
   `PTD_ASSERT(label, clk, rst, !(expr))

`endif

// ===== rtl/ptd_pkg.sv =====
// Types and constants of the permutation traffic destination block.
package ptd_pkg;

   // Field and register widths
   localparam int SRC_W      = 16;
   localparam int DEST_W     = 16;
   localparam int STATUS_W   = 3;
   localparam int MODE_W     = 3;
   localparam int NODES_W    = 17;
   localparam int RADIX_W    = 9;
   localparam int XR_W       = 5;
   localparam int DIGITS_W   = 5;
   localparam int LOG_W      = 5;
   localparam int BASE_W     = 14;
   localparam int SUM_W      = 18;
   localparam int PROD_W     = SUM_W + BASE_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   // Saturation level of the digit-mode range sum (above any node count)
   localparam logic [SUM_W-1:0] SUM_SAT = 18'h20000;

   // Pattern modes
   localparam logic [MODE_W-1:0] MODE_COMPLEMENT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_TRANSPOSE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_REVERSE    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SHUFFLE    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_TORNADO    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_NEIGHBOR   = 3'd5;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_POW2  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ODD_EXP   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NODE_COUNT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RADIX_K      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_EXPANSION_XR = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DIGIT_COUNT  = 3'd4;

   // One pipeline stage of work on an item
   typedef struct packed {
      logic [SRC_W-1:0]    src;
      logic [DEST_W-1:0]   dest;
      logic [STATUS_W-1:0] status;
      logic                digit;
      logic [BASE_W-1:0]   rem;
      logic [SRC_W-1:0]    dvd;
      logic [SRC_W-1:0]    quo;
      logic [BASE_W-1:0]   dig;
      logic [DEST_W-1:0]   off_w;
      logic [SUM_W-1:0]    off_s;
      logic [DEST_W-1:0]   res;
      logic [SUM_W-1:0]    sum;
      logic [DEST_W-1:0]   prod_w;
      logic [PROD_W-1:0]   prod_s;
      logic [DEST_W-1:0]   noff_w;
      logic [PROD_W-1:0]   noff_s;
   } pipe_type;

endpackage

// ===== rtl/permutation_traffic_destination_core.sv =====
// Top level: pipelined destination generator for synthetic permutation traffic.
//
// Request channel: req_valid / req_stall with req_source_node; one transfer per cycle while req_stall is low.
// Response channel: rsp_valid / rsp_stall with rsp_destination_node and rsp_status,
// one response per request, in request order.
// CSR port: csr_write_enable, csr_index, csr_write_data; write only while idle.
// Throughput: one transfer per cycle on both channels while neither channel stalls.
// Depth: 2 + sum over digits i < MAX_DIGITS of (max(15 - i, 0) + 3) pipeline
// stages plus the output register.
// The depth is set by the restoring divider chain that splits the source into
// base digits, one quotient bit per stage, followed by three stages per digit
// (digit offset, multiplies, accumulate).
// Reset clears all valids and loads the register defaults (complement mode,
// 64 nodes, radix 4, expansion 1, three digits).
// When rsp_stall holds a waiting response, the whole pipeline freezes and a
// one-entry skid buffer absorbs the request transfer of that cycle; req_stall
// is high while the skid entry is full.
`include "assert_macros.svh"

module permutation_traffic_destination_core #(
   parameter int ADDR_BITS  = 16,
   parameter int MAX_DIGITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ptd_pkg::SRC_W-1:0]        req_source_node,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ptd_pkg::DEST_W-1:0]       rsp_destination_node,
   output logic [ptd_pkg::STATUS_W-1:0]     rsp_status,
   input  logic                             csr_write_enable,
   input  logic [ptd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ptd_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   localparam int SRC_W    = ptd_pkg::SRC_W;
   localparam int DEST_W   = ptd_pkg::DEST_W;
   localparam int NODES_W  = ptd_pkg::NODES_W;
   localparam int BASE_W   = ptd_pkg::BASE_W;
   localparam int SUM_W    = ptd_pkg::SUM_W;
   localparam int PROD_W   = ptd_pkg::PROD_W;
   localparam int LOG_W    = ptd_pkg::LOG_W;
   localparam int DIGITS_W = ptd_pkg::DIGITS_W;

   localparam logic [63:0] ADDR_MASK_FULL = (64'd1 << ADDR_BITS) - 64'd1;
   localparam logic [DEST_W-1:0] DEST_MASK = ADDR_MASK_FULL[DEST_W-1:0];

   // Quotient-bit stages needed for digit i (source shrinks by one bit per digit)
   function automatic int div_steps(input int i);
      return (i < SRC_W - 1) ? (SRC_W - 1 - i) : 0;
   endfunction

   // First stage index of digit i
   function automatic int digit_start(input int i);
      int acc;
      acc = 2;
      for (int j = 0; j < i; j++) begin
         acc = acc + div_steps(j) + 3;
      end
      return acc;
   endfunction

   localparam int NST = digit_start(MAX_DIGITS);

   // Configuration registers
   logic [ptd_pkg::MODE_W-1:0]   mode_ff;
   logic [NODES_W-1:0]           node_count_ff;
   logic [ptd_pkg::RADIX_W-1:0]  radix_ff;
   logic [ptd_pkg::XR_W-1:0]     xr_ff;
   logic [DIGITS_W-1:0]          digit_count_ff;
   logic [BASE_W-1:0]            base_ff;
   logic [BASE_W-1:0]            add_ff;
   logic [BASE_W-1:0]            add_in;

   // Pipeline
   ptd_pkg::pipe_type            pipe_ff [NST];
   ptd_pkg::pipe_type            pipe_in [NST];
   logic [NST-1:0]               vld_ff;
   logic [NST-1:0]               vld_in;
   logic                         pipe_en;
   logic                         req_accept;

   // Skid entry
   logic                         skid_vld_ff;
   logic                         skid_vld_in;
   logic [SRC_W-1:0]             skid_src_ff;

   // Output register
   logic                         rsp_valid_ff;
   logic [DEST_W-1:0]            rsp_dest_ff;
   logic [DEST_W-1:0]            rsp_dest_in;
   logic [ptd_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [ptd_pkg::STATUS_W-1:0] rsp_status_in;

   // Register writes and derived digit base and offset
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= ptd_pkg::MODE_COMPLEMENT;
         node_count_ff  <= 17'd64;
         radix_ff       <= 9'd4;
         xr_ff          <= 5'd1;
         digit_count_ff <= 5'd3;
         base_ff        <= 14'd4;
         add_ff         <= 14'd1;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               ptd_pkg::REG_PATTERN_MODE: mode_ff        <= csr_write_data[2:0];
               ptd_pkg::REG_NODE_COUNT:   node_count_ff  <= csr_write_data[16:0];
               ptd_pkg::REG_RADIX_K:      radix_ff       <= csr_write_data[8:0];
               ptd_pkg::REG_EXPANSION_XR: xr_ff          <= csr_write_data[4:0];
               ptd_pkg::REG_DIGIT_COUNT:  digit_count_ff <= csr_write_data[4:0];
               default: ;
            endcase
         end
         base_ff <= BASE_W'(xr_ff * BASE_W'(radix_ff));
         add_ff  <= add_in;
      end
   end

   // Tornado steps by ceil(R/2)-1, neighbor by one
   always_comb begin
      if (mode_ff == ptd_pkg::MODE_TORNADO) begin
         add_in = BASE_W'((({1'b0, base_ff} + 15'd1) >> 1) - 15'd1);
      end else begin
         add_in = 14'd1;
      end
   end

   // Handshake: the pipeline moves unless a waiting response is stalled
   assign pipe_en     = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = skid_vld_ff;
   assign req_accept  = req_valid && !skid_vld_ff;
   assign skid_vld_in = pipe_en ? 1'b0 : (skid_vld_ff || req_accept);

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else begin
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!pipe_en && req_accept) begin
         skid_src_ff <= req_source_node;
      end
   end

   // Stage 0: take the skid entry first, else the new transfer
   always_comb begin
      pipe_in[0]     = '0;
      pipe_in[0].src = skid_vld_ff ? skid_src_ff : req_source_node;
   end

   assign vld_in = {vld_ff[NST-2:0], skid_vld_ff || req_accept};

   // Stage 1: range and power-of-two checks, bit permutations, digit setup
   always_comb begin
      logic [SRC_W-1:0]   s;
      logic [NODES_W-1:0] nc;
      logic [NODES_W-1:0] all_ones;
      logic [NODES_W-1:0] s_ext;
      logic [NODES_W-1:0] lo_mask;
      logic [NODES_W-1:0] hi_mask;
      logic [NODES_W-1:0] shl;
      logic [LOG_W-1:0]   n;
      logic [LOG_W-2:0]   h;
      logic               pow2;
      logic               in_range;
      logic [SRC_W-1:0]   rev;
      logic [DEST_W-1:0]  bit_dest;

      s        = pipe_ff[0].src;
      nc       = node_count_ff;
      s_ext    = {1'b0, s};
      all_ones = nc - 17'd1;
      pow2     = (nc != '0) && ((nc & all_ones) == '0);
      in_range = s_ext < nc;
      n        = '0;
      for (int b = 0; b < NODES_W; b++) begin
         if (nc[b]) n = LOG_W'(b);
      end
      for (int b = 0; b < SRC_W; b++) begin
         rev[b] = s[SRC_W-1-b];
      end
      h       = n[LOG_W-1:1];
      lo_mask = (17'd1 << h) - 17'd1;
      hi_mask = lo_mask << h;
      shl     = {s, 1'b0};

      case (mode_ff)
         ptd_pkg::MODE_COMPLEMENT: bit_dest = DEST_W'(~s_ext & all_ones);
         ptd_pkg::MODE_TRANSPOSE:
            bit_dest = DEST_W'(((s_ext >> h) & lo_mask) | ((s_ext << h) & hi_mask));
         ptd_pkg::MODE_REVERSE:    bit_dest = rev >> (LOG_W'(SRC_W) - n);
         ptd_pkg::MODE_SHUFFLE:
            bit_dest = DEST_W'((shl & all_ones) | NODES_W'((shl & nc) != '0));
         default:                  bit_dest = s;
      endcase

      pipe_in[1]        = pipe_ff[0];
      pipe_in[1].dest   = '0;
      pipe_in[1].status = ptd_pkg::ST_OK;
      pipe_in[1].digit  = 1'b0;
      pipe_in[1].quo    = s;
      pipe_in[1].off_w  = 16'd1;
      pipe_in[1].off_s  = 18'd1;
      pipe_in[1].res    = '0;
      pipe_in[1].sum    = '0;

      if (mode_ff inside {ptd_pkg::MODE_COMPLEMENT, ptd_pkg::MODE_TRANSPOSE,
                          ptd_pkg::MODE_REVERSE, ptd_pkg::MODE_SHUFFLE}) begin
         if (!pow2) begin
            pipe_in[1].status = ptd_pkg::ST_NOT_POW2;
         end else if (mode_ff == ptd_pkg::MODE_TRANSPOSE && n[0]) begin
            pipe_in[1].status = ptd_pkg::ST_ODD_EXP;
         end else if (!in_range) begin
            pipe_in[1].status = ptd_pkg::ST_RANGE;
         end else begin
            pipe_in[1].dest = bit_dest;
         end
      end else if (!in_range) begin
         pipe_in[1].status = ptd_pkg::ST_RANGE;
      end else if (mode_ff inside {ptd_pkg::MODE_TORNADO, ptd_pkg::MODE_NEIGHBOR}) begin
         pipe_in[1].digit = 1'b1;
      end else begin
         pipe_in[1].dest = s;
      end
   end

   // Digit stages: divide by the base, offset the digit, weight and accumulate
   for (genvar gi = 0; gi < MAX_DIGITS; gi++) begin : g_digit
      localparam int B  = digit_start(gi);
      localparam int NS = div_steps(gi);

      logic [BASE_W-1:0] rem0;

      // Leading dividend bit starts the partial remainder (correct for a base of at least two)
      if (gi < SRC_W) begin : g_lead
         assign rem0 = {{(BASE_W-1){1'b0}}, pipe_ff[B-1].quo[SRC_W-1-gi]};
      end else begin : g_zero
         assign rem0 = '0;
      end

      // Restoring division, one quotient bit per stage
      for (genvar gj = 0; gj < NS; gj++) begin : g_step
         always_comb begin
            logic [BASE_W:0] trial;
            pipe_in[B+gj] = pipe_ff[B+gj-1];
            if (gj == 0) begin
               pipe_in[B+gj].rem = rem0;
               pipe_in[B+gj].dvd = pipe_ff[B+gj-1].quo << (gi + 1);
               pipe_in[B+gj].quo = '0;
            end
            trial = {pipe_in[B+gj].rem, pipe_in[B+gj].dvd[SRC_W-1]};
            if (trial >= {1'b0, base_ff}) begin
               trial = trial - {1'b0, base_ff};
               pipe_in[B+gj].quo = {pipe_in[B+gj].quo[SRC_W-2:0], 1'b1};
            end else begin
               pipe_in[B+gj].quo = {pipe_in[B+gj].quo[SRC_W-2:0], 1'b0};
            end
            pipe_in[B+gj].rem = trial[BASE_W-1:0];
            pipe_in[B+gj].dvd = {pipe_in[B+gj].dvd[SRC_W-2:0], 1'b0};
         end
      end

      // Digit plus offset, modulo the base
      always_comb begin
         logic [BASE_W:0] total;
         pipe_in[B+NS] = pipe_ff[B+NS-1];
         if (NS == 0) begin
            pipe_in[B+NS].rem = rem0;
            pipe_in[B+NS].quo = '0;
         end
         total = {1'b0, pipe_in[B+NS].rem} + {1'b0, add_ff};
         if (total >= {1'b0, base_ff}) begin
            total = total - {1'b0, base_ff};
         end
         pipe_in[B+NS].dig = total[BASE_W-1:0];
      end

      // Weighted digit and next place value
      always_comb begin
         pipe_in[B+NS+1]        = pipe_ff[B+NS];
         pipe_in[B+NS+1].prod_w = pipe_ff[B+NS].off_w * DEST_W'(pipe_ff[B+NS].dig);
         pipe_in[B+NS+1].prod_s = PROD_W'(pipe_ff[B+NS].off_s) * PROD_W'(pipe_ff[B+NS].dig);
         pipe_in[B+NS+1].noff_w = pipe_ff[B+NS].off_w * DEST_W'(base_ff);
         pipe_in[B+NS+1].noff_s = PROD_W'(pipe_ff[B+NS].off_s) * PROD_W'(base_ff);
      end

      // Accumulate: wrapped result and saturated true value
      always_comb begin
         logic [SUM_W-1:0] part;
         logic [SUM_W:0]   acc;
         pipe_in[B+NS+2] = pipe_ff[B+NS+1];
         part = (pipe_ff[B+NS+1].prod_s >= PROD_W'(ptd_pkg::SUM_SAT)) ?
                ptd_pkg::SUM_SAT : pipe_ff[B+NS+1].prod_s[SUM_W-1:0];
         acc  = {1'b0, pipe_ff[B+NS+1].sum} + {1'b0, part};
         if (DIGITS_W'(gi) < digit_count_ff) begin
            pipe_in[B+NS+2].res = pipe_ff[B+NS+1].res + pipe_ff[B+NS+1].prod_w;
            pipe_in[B+NS+2].sum = (acc >= {1'b0, ptd_pkg::SUM_SAT}) ?
                                  ptd_pkg::SUM_SAT : acc[SUM_W-1:0];
         end
         pipe_in[B+NS+2].off_w = pipe_ff[B+NS+1].noff_w;
         pipe_in[B+NS+2].off_s = (pipe_ff[B+NS+1].noff_s >= PROD_W'(ptd_pkg::SUM_SAT)) ?
                                 ptd_pkg::SUM_SAT : pipe_ff[B+NS+1].noff_s[SUM_W-1:0];
      end
   end

   // Pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         pipe_ff <= pipe_in;
      end
   end

   // Final status for digit modes; a base below two yields destination zero
   always_comb begin
      rsp_dest_in   = pipe_ff[NST-1].dest;
      rsp_status_in = pipe_ff[NST-1].status;
      if (pipe_ff[NST-1].digit && pipe_ff[NST-1].status == ptd_pkg::ST_OK) begin
         if (base_ff < 14'd2) begin
            rsp_dest_in = '0;
         end else begin
            rsp_dest_in = pipe_ff[NST-1].res;
            if (pipe_ff[NST-1].sum >= {1'b0, node_count_ff}) begin
               rsp_status_in = ptd_pkg::ST_TOO_LARGE;
            end
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= vld_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_dest_ff   <= rsp_dest_in & DEST_MASK;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_destination_node = rsp_dest_ff;
   assign rsp_status           = rsp_status_ff;

   // Checks
   `PTD_ASSERT(a_error_dest_zero, clock, reset,
      rsp_valid_ff && (rsp_status_ff == ptd_pkg::ST_RANGE ||
      rsp_status_ff == ptd_pkg::ST_NOT_POW2 || rsp_status_ff == ptd_pkg::ST_ODD_EXP)
      |-> rsp_dest_ff == '0)
   `PTD_ASSERT(a_skid_drains, clock, reset, skid_vld_ff && pipe_en |=> !skid_vld_ff)
   `PTD_ASSERT(a_frozen_valids, clock, reset, !pipe_en |=> $stable(vld_ff))

endmodule
